// ===== hw/rtl/udp_socket_demux_table_top_assert.svh =====
// ----------------------------------------------------------------------------
// udp socket demux table assertion macros
// concurrent assertion wrappers shared by the table's rtl modules
// ----------------------------------------------------------------------------
`ifndef UDP_SOCKET_DEMUX_TABLE_TOP_ASSERT_SVH
`define UDP_SOCKET_DEMUX_TABLE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define UDPDMX_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define UDPDMX_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define UDPDMX_ASSERT(lbl, clk, rst_n, prop, msg)

`define UDPDMX_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== hw/rtl/udpdmx_pkg.sv =====
// ----------------------------------------------------------------------------
// udp socket demux table package
// field widths, command and status codes, controller/datapath interface types
// ----------------------------------------------------------------------------
package udpdmx_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 16;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned PORT_W   = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned SCORE_W  = 3;

    localparam logic [CMD_W-1:0] CMD_BIND       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_REMOTE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PORT_IN_USE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD         = 3'd4;

    localparam logic [SCORE_W-1:0] SCORE_NONE = 3'd0;
    localparam logic [SCORE_W-1:0] SCORE_FULL = 3'd7;

    // which result the datapath latches when a request finishes
    typedef enum logic [2:0] {
        FIN_BAD,
        FIN_IN_USE,
        FIN_FULL,
        FIN_BIND_OK,
        FIN_SET_OK,
        FIN_LOOKUP
    } fin_kind_t;

    typedef struct packed {
        logic      load;
        logic      start;
        logic      fin;
        fin_kind_t kind;
    } dmx_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             port_zero;
        logic             slot_bad;
        logic             empty;
        logic             full;
        logic             rd_vld;
        logic             rd_last;
        logic             port_hit;
        logic             full_hit;
    } dmx_sts_t;

endpackage

// ===== hw/rtl/udpdmx_ctrl.sv =====
// ----------------------------------------------------------------------------
// udp socket demux table controller
// request sequencing: decode, table scan, result handshake
// ----------------------------------------------------------------------------
`include "udp_socket_demux_table_top_assert.svh"

module udpdmx_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  udpdmx_pkg::dmx_sts_t sts,
    output udpdmx_pkg::dmx_ctl_t ctl
);
    import udpdmx_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        ctl.load       = 1'b0;
        ctl.start      = 1'b0;
        ctl.fin        = 1'b0;
        ctl.kind       = FIN_BAD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.cmd)
                    CMD_BIND:
                    begin
                        if (sts.port_zero)
                        begin
                            ctl.fin  = 1'b1;
                            ctl.kind = FIN_BAD;
                        end
                        else if (sts.empty)
                        begin
                            ctl.fin  = 1'b1;
                            ctl.kind = FIN_BIND_OK;
                        end
                        else
                        begin
                            ctl.start = 1'b1;
                        end
                    end
                    CMD_SET_REMOTE:
                    begin
                        ctl.fin  = 1'b1;
                        ctl.kind = sts.slot_bad ? FIN_BAD : FIN_SET_OK;
                    end
                    CMD_LOOKUP:
                    begin
                        if (sts.empty)
                        begin
                            ctl.fin  = 1'b1;
                            ctl.kind = FIN_LOOKUP;
                        end
                        else
                        begin
                            ctl.start = 1'b1;
                        end
                    end
                    default:
                    begin
                        ctl.fin  = 1'b1;
                        ctl.kind = FIN_BAD;
                    end
                endcase
                if (ctl.fin)
                begin
                    state_next     = S_RESP;
                    out_valid_next = 1'b1;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.cmd == CMD_BIND)
                begin
                    // a held port ends the scan at once
                    if (sts.port_hit)
                    begin
                        ctl.fin  = 1'b1;
                        ctl.kind = FIN_IN_USE;
                    end
                    else if (sts.rd_vld && sts.rd_last)
                    begin
                        ctl.fin  = 1'b1;
                        ctl.kind = sts.full ? FIN_FULL : FIN_BIND_OK;
                    end
                end
                else
                begin
                    if (sts.full_hit || (sts.rd_vld && sts.rd_last))
                    begin
                        ctl.fin  = 1'b1;
                        ctl.kind = FIN_LOOKUP;
                    end
                end
                if (ctl.fin)
                begin
                    state_next     = S_RESP;
                    out_valid_next = 1'b1;
                end
            end
            S_RESP:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    `UDPDMX_ASSERT(a_one_request, clk, rst_n, in_valid && !in_stall |=> in_stall, "request accepted while another in flight")
    `UDPDMX_ASSERT(a_resp_once, clk, rst_n, out_valid && !out_stall |=> !out_valid, "result delivered twice")
    `UDPDMX_ASSERT_NEVER(a_scan_empty, clk, rst_n, ctl.start && sts.empty, "scan started on empty table")

endmodule

// ===== hw/rtl/udpdmx_dpath.sv =====
// ----------------------------------------------------------------------------
// udp socket demux table datapath
// request registers, entry memories, scan pointer, match scoring, result
// ----------------------------------------------------------------------------
`include "udp_socket_demux_table_top_assert.svh"

module udpdmx_dpath #(
    parameter int unsigned TABLE_ENTRIES = udpdmx_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  udpdmx_pkg::dmx_ctl_t              ctl,
    output udpdmx_pkg::dmx_sts_t              sts,
    input  logic [udpdmx_pkg::CMD_W-1:0]      cmd,
    input  logic [udpdmx_pkg::SLOT_W-1:0]     slot,
    input  logic [udpdmx_pkg::ADDR_W-1:0]     local_addr,
    input  logic [udpdmx_pkg::PORT_W-1:0]     local_port,
    input  logic [udpdmx_pkg::ADDR_W-1:0]     remote_addr,
    input  logic [udpdmx_pkg::PORT_W-1:0]     remote_port,
    output logic [udpdmx_pkg::STATUS_W-1:0]   status,
    output logic [udpdmx_pkg::SLOT_W-1:0]     hit_slot,
    output logic [udpdmx_pkg::SCORE_W-1:0]    match_score
);
    import udpdmx_pkg::*;

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned SW = (CW > SLOT_W) ? CW : SLOT_W;
    localparam int unsigned HW = (IW > SLOT_W) ? IW : SLOT_W;
    localparam int unsigned EW = ADDR_W + PORT_W;
    localparam logic [CW-1:0] FILL_MAX = CW'(TABLE_ENTRIES);

    // request registers
    logic [CMD_W-1:0]  cmd_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [ADDR_W-1:0] laddr_reg;
    logic [PORT_W-1:0] lport_reg;
    logic [ADDR_W-1:0] raddr_reg;
    logic [PORT_W-1:0] rport_reg;

    // entry store: {address, port} for local and remote side
    logic [EW-1:0] loc_mem [TABLE_ENTRIES];
    logic [EW-1:0] rem_mem [TABLE_ENTRIES];
    logic [EW-1:0] loc_rd_reg;
    logic [EW-1:0] rem_rd_reg;

    logic [CW-1:0]      fill_reg;
    logic [CW-1:0]      fill_m1;
    logic [IW-1:0]      ptr_reg;
    logic               issue_reg;
    logic               rd_vld_reg;
    logic               rd_last_reg;
    logic [IW-1:0]      rd_idx_reg;
    logic [SCORE_W-1:0] best_score_reg;
    logic [IW-1:0]      best_slot_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   hit_slot_reg;
    logic [SCORE_W-1:0]  score_reg;

    logic               scan_up;
    logic               ptr_last;
    logic [SW-1:0]      slot_ext;
    logic [IW-1:0]      wr_addr;
    logic               wr_bind;
    logic               wr_set;

    logic [ADDR_W-1:0]  e_laddr;
    logic [PORT_W-1:0]  e_lport;
    logic [ADDR_W-1:0]  e_raddr;
    logic [PORT_W-1:0]  e_rport;
    logic               la_nz;
    logic               ra_nz;
    logic               rp_nz;
    logic               port_eq;
    logic               match;
    logic [1:0]         nz_cnt;
    logic [SCORE_W-1:0] score;
    logic               better;
    logic [SCORE_W-1:0] best_score_nx;
    logic [IW-1:0]      best_slot_nx;
    logic [HW-1:0]      best_slot_ext;
    logic [HW-1:0]      fill_ext;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= cmd;
            slot_reg  <= slot;
            laddr_reg <= local_addr;
            lport_reg <= local_port;
            raddr_reg <= remote_addr;
            rport_reg <= remote_port;
        end
    end

    assign scan_up  = (cmd_reg == CMD_BIND);
    assign fill_m1  = fill_reg - CW'(1);
    assign ptr_last = scan_up ? (ptr_reg == fill_m1[IW-1:0]) : (ptr_reg == '0);
    assign slot_ext = SW'(slot_reg);
    assign wr_bind  = ctl.fin && (ctl.kind == FIN_BIND_OK);
    assign wr_set   = ctl.fin && (ctl.kind == FIN_SET_OK);
    assign wr_addr  = wr_bind ? fill_reg[IW-1:0] : slot_ext[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_bind)
        begin
            loc_mem[wr_addr] <= {laddr_reg, lport_reg};
            rem_mem[wr_addr] <= '0;
        end
        else if (wr_set)
        begin
            rem_mem[wr_addr] <= {raddr_reg, rport_reg};
        end
        if (issue_reg)
        begin
            loc_rd_reg <= loc_mem[ptr_reg];
            rem_rd_reg <= rem_mem[ptr_reg];
        end
    end

    // scan pointer: binds walk up from slot zero, lookups walk down from newest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            issue_reg   <= 1'b0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            rd_idx_reg  <= '0;
        end
        else if (ctl.start)
        begin
            ptr_reg    <= scan_up ? '0 : fill_m1[IW-1:0];
            issue_reg  <= 1'b1;
            rd_vld_reg <= 1'b0;
        end
        else if (ctl.fin)
        begin
            issue_reg  <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= issue_reg;
            rd_last_reg <= ptr_last;
            rd_idx_reg  <= ptr_reg;
            if (issue_reg)
            begin
                ptr_reg <= scan_up ? (ptr_reg + IW'(1)) : (ptr_reg - IW'(1));
                if (ptr_last)
                begin
                    issue_reg <= 1'b0;
                end
            end
        end
    end

    assign e_laddr = loc_rd_reg[EW-1:PORT_W];
    assign e_lport = loc_rd_reg[PORT_W-1:0];
    assign e_raddr = rem_rd_reg[EW-1:PORT_W];
    assign e_rport = rem_rd_reg[PORT_W-1:0];

    assign la_nz   = (e_laddr != '0);
    assign ra_nz   = (e_raddr != '0);
    assign rp_nz   = (e_rport != '0);
    assign port_eq = (e_lport == lport_reg);
    assign match   = rd_vld_reg && port_eq
                     && (!la_nz || (e_laddr == laddr_reg))
                     && (!ra_nz || (e_raddr == raddr_reg))
                     && (!rp_nz || (e_rport == rport_reg));
    // one plus two per matched specific field
    assign nz_cnt  = {1'b0, la_nz} + {1'b0, ra_nz} + {1'b0, rp_nz};
    assign score   = {nz_cnt, 1'b1};
    // strict compare keeps the newer slot on ties since the walk goes downward
    assign better  = match && (score > best_score_reg);

    assign best_score_nx = better ? score : best_score_reg;
    assign best_slot_nx  = better ? rd_idx_reg : best_slot_reg;
    assign best_slot_ext = HW'(best_slot_nx);
    assign fill_ext      = HW'(fill_reg[IW-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            best_score_reg <= SCORE_NONE;
            best_slot_reg  <= '0;
        end
        else
        begin
            if (wr_bind)
            begin
                fill_reg <= fill_reg + CW'(1);
            end
            if (ctl.start)
            begin
                best_score_reg <= SCORE_NONE;
                best_slot_reg  <= '0;
            end
            else
            begin
                best_score_reg <= best_score_nx;
                best_slot_reg  <= best_slot_nx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fin)
        begin
            hit_slot_reg <= '0;
            score_reg    <= SCORE_NONE;
            unique case (ctl.kind)
                FIN_IN_USE:  status_reg <= ST_PORT_IN_USE;
                FIN_FULL:    status_reg <= ST_TABLE_FULL;
                FIN_BIND_OK:
                begin
                    status_reg   <= ST_OK;
                    hit_slot_reg <= fill_ext[SLOT_W-1:0];
                end
                FIN_SET_OK:
                begin
                    status_reg   <= ST_OK;
                    hit_slot_reg <= slot_reg;
                end
                FIN_LOOKUP:
                begin
                    if (best_score_nx == SCORE_NONE)
                    begin
                        status_reg <= ST_NO_MATCH;
                    end
                    else
                    begin
                        status_reg   <= ST_OK;
                        hit_slot_reg <= best_slot_ext[SLOT_W-1:0];
                        score_reg    <= best_score_nx;
                    end
                end
                default:     status_reg <= ST_BAD;
            endcase
        end
    end

    assign status      = status_reg;
    assign hit_slot    = hit_slot_reg;
    assign match_score = score_reg;

    assign sts.cmd       = cmd_reg;
    assign sts.port_zero = (lport_reg == '0);
    assign sts.slot_bad  = (slot_ext >= SW'(fill_reg));
    assign sts.empty     = (fill_reg == '0);
    assign sts.full      = (fill_reg == FILL_MAX);
    assign sts.rd_vld    = rd_vld_reg;
    assign sts.rd_last   = rd_last_reg;
    assign sts.port_hit  = rd_vld_reg && port_eq;
    assign sts.full_hit  = match && (score == SCORE_FULL);

    `UDPDMX_ASSERT_NEVER(a_fill_range, clk, rst_n, fill_reg > FILL_MAX, "fill count beyond table size")
    `UDPDMX_ASSERT(a_fill_by_bind, clk, rst_n, fill_reg != $past(fill_reg) |-> $past(wr_bind), "fill count moved without a bind")
    `UDPDMX_ASSERT(a_read_issued, clk, rst_n, rd_vld_reg |-> $past(issue_reg), "read data flagged without a read issued")

endmodule

// ===== hw/rtl/udp_socket_demux_table_top.sv =====
// ----------------------------------------------------------------------------
// udp socket demux table
// socket table with bind, set-remote and wildcard best-match lookup
// ----------------------------------------------------------------------------
// One request is handled at a time. Set-remote, rejected binds (port zero)
// and requests on an empty table present their result straight from the
// decode state; bind and lookup read the entry memory through its
// single read port, one bound entry per cycle, and present the result once
// the scan ends: after all bound entries are read, or earlier when a held
// port (bind) or a full-score match (lookup) ends the scan.
// The next request is taken the cycle after the result is taken.
// Entries are appended in slot order; a zero address or remote port in an
// entry matches anything, and on equal score the higher slot wins.
module udp_socket_demux_table_top #(
    parameter int unsigned TABLE_ENTRIES = udpdmx_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [udpdmx_pkg::CMD_W-1:0]      cmd,
    input  logic [udpdmx_pkg::SLOT_W-1:0]     slot,
    input  logic [udpdmx_pkg::ADDR_W-1:0]     local_addr,
    input  logic [udpdmx_pkg::PORT_W-1:0]     local_port,
    input  logic [udpdmx_pkg::ADDR_W-1:0]     remote_addr,
    input  logic [udpdmx_pkg::PORT_W-1:0]     remote_port,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [udpdmx_pkg::STATUS_W-1:0]   status,
    output logic [udpdmx_pkg::SLOT_W-1:0]     hit_slot,
    output logic [udpdmx_pkg::SCORE_W-1:0]    match_score
);
    import udpdmx_pkg::*;

    dmx_ctl_t ctl;
    dmx_sts_t sts;

    udpdmx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    udpdmx_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .cmd         (cmd),
        .slot        (slot),
        .local_addr  (local_addr),
        .local_port  (local_port),
        .remote_addr (remote_addr),
        .remote_port (remote_port),
        .status      (status),
        .hit_slot    (hit_slot),
        .match_score (match_score)
    );

endmodule
